// ===== hw/rtl/rsfl_pkg.sv =====
// rsfl_pkg: shared types, codes and defaults for the record slot free list unit
// used by rsfl_ctrl and record_slot_free_list_unit; no dependencies
package rsfl_pkg;

    localparam int SLOTS_DEFAULT        = 256;
    localparam int PAYLOAD_BITS_DEFAULT = 64;
    localparam int SLOT_W               = 8;
    localparam int DATA_W               = 64;
    localparam int ACTION_W             = 2;
    localparam int STATUS_W             = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FREED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNALLOC = 2'd3
    } status_t;

    typedef struct packed {
        logic link;
        logic live;
        logic rec;
    } mem_we_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  placed_slot;
        logic [DATA_W-1:0]  read_data;
        logic               live;
    } result_t;

endpackage

// ===== hw/rtl/rsfl_ram.sv =====
// rsfl_ram: simple dual-port memory, one write and one registered read port
// write-first on an address collision; no dependencies
module rsfl_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
        if (re) begin
            if (we && (waddr == raddr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= mem_array[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rsfl_ctrl.sv =====
// rsfl_ctrl: free list state and per-beat decision logic
// depends on rsfl_pkg; memory read data comes from rsfl_ram instances in the top level
module rsfl_ctrl
    import rsfl_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT,
    localparam int IDX_W       = $clog2(SLOTS),
    localparam int CNT_W       = $clog2(SLOTS + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    fire,
    input  action_t                 action,
    input  logic [SLOT_W-1:0]       slot,
    input  logic [IDX_W-1:0]        link_rd,
    input  logic                    live_rd,
    input  logic [PAYLOAD_BITS-1:0] rec_rd,
    output mem_we_t                 we,
    output logic [IDX_W-1:0]        wr_slot,
    output logic [IDX_W-1:0]        link_wdata,
    output logic                    live_wdata,
    output logic [IDX_W-1:0]        head_next,
    output result_t                 result
);

    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic             free_empty_reg, free_empty_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;
    logic [CNT_W-1:0] free_count_reg, free_count_next;
    mem_we_t          we_c;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_alloc;

    assign slot_idx   = IDX_W'(slot);
    assign slot_alloc = CMP_W'(slot) < CMP_W'(used_count_reg);

    always_comb begin
        free_head_next  = free_head_reg;
        free_empty_next = free_empty_reg;
        used_count_next = used_count_reg;
        free_count_next = free_count_reg;
        we_c            = '0;
        wr_slot         = '0;
        link_wdata      = '0;
        live_wdata      = 1'b0;
        result          = '0;
        result.status   = ST_OK;
        unique case (action)
            ACT_ADD: begin
                if (!free_empty_reg) begin
                    wr_slot            = free_head_reg;
                    free_head_next     = link_rd;
                    free_count_next    = free_count_reg - CNT_W'(1);
                    free_empty_next    = (free_count_reg == CNT_W'(1));
                    we_c.live          = 1'b1;
                    we_c.rec           = 1'b1;
                    live_wdata         = 1'b1;
                    result.placed_slot = SLOT_W'(free_head_reg);
                end else if (used_count_reg < CNT_W'(SLOTS)) begin
                    wr_slot            = used_count_reg[IDX_W-1:0];
                    used_count_next    = used_count_reg + CNT_W'(1);
                    we_c.live          = 1'b1;
                    we_c.rec           = 1'b1;
                    live_wdata         = 1'b1;
                    result.placed_slot = SLOT_W'(used_count_reg[IDX_W-1:0]);
                end else begin
                    result.status = ST_FULL;
                end
            end
            ACT_DELETE: begin
                if (!slot_alloc) begin
                    result.status = ST_UNALLOC;
                end else if (!live_rd) begin
                    result.status = ST_FREED;
                end else begin
                    we_c.link       = 1'b1;
                    we_c.live       = 1'b1;
                    wr_slot         = slot_idx;
                    link_wdata      = free_empty_reg ? '0 : free_head_reg;
                    free_head_next  = slot_idx;
                    free_empty_next = 1'b0;
                    free_count_next = free_count_reg + CNT_W'(1);
                end
            end
            ACT_READ: begin
                if (!slot_alloc) begin
                    result.status = ST_UNALLOC;
                end else begin
                    result.read_data = DATA_W'(rec_rd);
                    result.live      = live_rd;
                end
            end
            ACT_NOP: begin
            end
            default: begin
            end
        endcase
    end

    assign we        = fire ? we_c : '0;
    assign head_next = fire ? free_head_next : free_head_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= '0;
            free_empty_reg <= 1'b1;
            used_count_reg <= '0;
            free_count_reg <= '0;
        end else if (fire) begin
            free_head_reg  <= free_head_next;
            free_empty_reg <= free_empty_next;
            used_count_reg <= used_count_next;
            free_count_reg <= free_count_next;
        end
    end

endmodule

// ===== hw/rtl/record_slot_free_list_unit.sv =====
// record_slot_free_list_unit: top level, input and result registers, slot memories
// depends on rsfl_pkg, rsfl_ram and rsfl_ctrl
//
// Fixed-slot record store with a LIFO free list of deleted slots.
// Input channel s_*: one beat per operation (add, delete, read or no-op).
// Result channel m_*: exactly one result beat per input beat, in order.
// An add takes the most recently freed slot, otherwise the next never-used
// slot; status reports full store, double delete and never-allocated slots.
// A beat is held in the input register, with the link, live and record
// memories read as it was accepted, until the result register can take it;
// it is then decided and written back as it moves into the result register.
// Throughput: one beat per cycle unless m_ready stalls the result channel;
// memory writes are forwarded to the reads of the following beat in the memories.
// Reset (aresetn low, synchronous) empties the free list and marks every
// slot as never used; memory contents are not cleared and need no sweep.
// When m_ready is low the result is held and at most one more beat is
// taken into the input register, after which s_ready drops.
module record_slot_free_list_unit
    import rsfl_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [DATA_W-1:0]   s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [SLOT_W-1:0]   m_placed_slot,
    output logic [DATA_W-1:0]   m_read_data,
    output logic                m_live
);

    localparam int IDX_W = $clog2(SLOTS);

    logic                    p_valid_reg;
    action_t                 p_action_reg;
    logic [SLOT_W-1:0]       p_slot_reg;
    logic [PAYLOAD_BITS-1:0] p_payload_reg;
    logic                    m_valid_reg;
    result_t                 m_result_reg;

    logic                    advance, fire, accept;
    mem_we_t                 we;
    logic [IDX_W-1:0]        wr_slot, link_wdata, head_next, link_rd, rd_addr;
    logic                    live_wdata, live_rd;
    logic [PAYLOAD_BITS-1:0] rec_rd;
    result_t                 result;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = p_valid_reg && advance;
    assign s_ready = !p_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign rd_addr = IDX_W'(s_slot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= 1'b1;
        end else if (fire) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_action_reg  <= action_t'(s_action);
            p_slot_reg    <= s_slot;
            p_payload_reg <= s_payload[PAYLOAD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_result_reg <= result;
        end
    end

    rsfl_ram #(.DEPTH(SLOTS), .WIDTH(IDX_W)) u_link_ram (
        .aclk  (aclk),
        .we    (we.link),
        .waddr (wr_slot),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (head_next),
        .rdata (link_rd)
    );

    rsfl_ram #(.DEPTH(SLOTS), .WIDTH(1)) u_live_ram (
        .aclk  (aclk),
        .we    (we.live),
        .waddr (wr_slot),
        .wdata (live_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (live_rd)
    );

    rsfl_ram #(.DEPTH(SLOTS), .WIDTH(PAYLOAD_BITS)) u_rec_ram (
        .aclk  (aclk),
        .we    (we.rec),
        .waddr (wr_slot),
        .wdata (p_payload_reg),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rec_rd)
    );

    rsfl_ctrl #(.SLOTS(SLOTS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .action     (p_action_reg),
        .slot       (p_slot_reg),
        .link_rd    (link_rd),
        .live_rd    (live_rd),
        .rec_rd     (rec_rd),
        .we         (we),
        .wr_slot    (wr_slot),
        .link_wdata (link_wdata),
        .live_wdata (live_wdata),
        .head_next  (head_next),
        .result     (result)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_result_reg.status;
    assign m_placed_slot = m_result_reg.placed_slot;
    assign m_read_data   = m_result_reg.read_data;
    assign m_live        = m_result_reg.live;

    // a delete pushing onto the free list clears the live mark and stores nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        we.link |-> (we.live && !we.rec && !live_wdata))
        else $error("free list push without live clear");

    // record writes only come from adds and always set the live mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        we.rec |-> (we.live && live_wdata && p_action_reg == ACT_ADD))
        else $error("record write outside an add");

    // a decided beat always reaches the result register as a valid result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("decided beat lost before result register");

    // a live mark is only reported with an ok status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_result_reg.live) |-> (m_result_reg.status == ST_OK))
        else $error("live reported with error status");

endmodule

// ===== sim/rsfl_result_check.sv =====
// rsfl_result_check: watches both channels of the record slot free list unit,
// keeps its own copy of the free list and slot store, and compares every result beat
// depends on rsfl_pkg only
`timescale 1ns / 1ps

module rsfl_result_check
    import rsfl_pkg::*;
#(
    parameter int SLOTS        = SLOTS_DEFAULT,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  logic [ACTION_W-1:0] s_action,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [DATA_W-1:0]   s_payload,
    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [STATUS_W-1:0] m_status,
    input  logic [SLOT_W-1:0]   m_placed_slot,
    input  logic [DATA_W-1:0]   m_read_data,
    input  logic                m_live,
    output int                  mismatches,
    output int                  pending,
    output int                  results_seen,
    output int                  full_seen,
    output int                  freed_seen,
    output int                  unalloc_seen
);

    localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - PAYLOAD_BITS);

    int                free_head  = 0;
    logic              free_empty = 1'b1;
    int                free_size  = 0;
    int                handed_out = 0;
    int                link_mem [SLOTS];
    logic              live_mem [SLOTS];
    logic [DATA_W-1:0] word_mem [SLOTS];

    result_t pending_results[$];

    int err_n     = 0;
    int seen_n    = 0;
    int full_n    = 0;
    int freed_n   = 0;
    int unalloc_n = 0;

    function automatic result_t predict_slot_op(input action_t act,
                                                input logic [SLOT_W-1:0] idx,
                                                input logic [DATA_W-1:0] word);
        result_t res;
        int      s;
        res        = '0;
        res.status = ST_OK;
        s          = -1;
        case (act)
            ACT_ADD: begin
                if (!free_empty) begin
                    s         = free_head;
                    free_head = link_mem[s];
                    if (free_size > 0) free_size--;
                    if (free_size == 0) free_empty = 1'b1;
                end else if (handed_out < SLOTS) begin
                    s = handed_out;
                    handed_out++;
                end else begin
                    res.status = ST_FULL;
                end
                if (s >= 0) begin
                    word_mem[s]     = word & WORD_MASK;
                    live_mem[s]     = 1'b1;
                    res.placed_slot = SLOT_W'(s);
                end
            end
            ACT_DELETE, ACT_READ: begin
                if (int'(idx) >= handed_out || int'(idx) >= SLOTS) begin
                    res.status = ST_UNALLOC;
                end else if (act == ACT_DELETE) begin
                    if (!live_mem[idx]) begin
                        res.status = ST_FREED;
                    end else begin
                        live_mem[idx] = 1'b0;
                        link_mem[idx] = free_empty ? 0 : free_head;
                        free_head     = int'(idx);
                        free_empty    = 1'b0;
                        free_size++;
                    end
                end else begin
                    res.read_data = word_mem[idx];
                    res.live      = live_mem[idx];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            free_head  = 0;
            free_empty = 1'b1;
            free_size  = 0;
            handed_out = 0;
            foreach (live_mem[i]) live_mem[i] = 1'b0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got.status      = status_t'(m_status);
                got.placed_slot = m_placed_slot;
                got.read_data   = m_read_data;
                got.live        = m_live;
                if (pending_results.size() == 0) begin
                    err_n++;
                    if (err_n <= 10)
                        $display("%0t: result beat with nothing outstanding: status %0d slot %0d",
                                 $realtime, m_status, m_placed_slot);
                end else begin
                    want = pending_results.pop_front();
                    seen_n++;
                    case (want.status)
                        ST_FULL:    full_n++;
                        ST_FREED:   freed_n++;
                        ST_UNALLOC: unalloc_n++;
                        default: ;
                    endcase
                    if (got.status !== want.status || got.placed_slot !== want.placed_slot ||
                        got.read_data !== want.read_data || got.live !== want.live) begin
                        err_n++;
                        if (err_n <= 10) begin
                            $display("%0t: result beat %0d mismatch", $realtime, seen_n);
                            $display("  expected status %0d slot %0d data %h live %0d",
                                     want.status, want.placed_slot, want.read_data, want.live);
                            $display("  actual   status %0d slot %0d data %h live %0d",
                                     m_status, m_placed_slot, m_read_data, m_live);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                pending_results.insert(pending_results.size(),
                                       predict_slot_op(action_t'(s_action), s_slot,
                                                       s_payload));
        end
        mismatches   <= err_n;
        pending      <= pending_results.size();
        results_seen <= seen_n;
        full_seen    <= full_n;
        freed_seen   <= freed_n;
        unalloc_seen <= unalloc_n;
    end

endmodule

// ===== sim/record_slot_free_list_unit_tb.sv =====
// record_slot_free_list_unit_tb: drives directed then random add, delete, read and
// no-op beats with bursty sending and patterned back-pressure, and gives the verdict
// depends on rsfl_pkg, record_slot_free_list_unit and rsfl_result_check
`timescale 1ns / 1ps

module record_slot_free_list_unit_tb;
    import rsfl_pkg::*;

    localparam int FILL_BEATS = 300;
    localparam int MIX_BEATS  = 120;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [ACTION_W-1:0] s_action;
    logic [SLOT_W-1:0]   s_slot;
    logic [DATA_W-1:0]   s_payload;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [SLOT_W-1:0]   m_placed_slot;
    logic [DATA_W-1:0]   m_read_data;
    logic                m_live;

    int mismatches;
    int pending;
    int results_seen;
    int full_seen;
    int freed_seen;
    int unalloc_seen;

    int adds_sent  = 0;
    int beats_sent = 0;
    int burst_left = 8;
    int rx_cycle   = 0;
    int rx_hold    = 0;

    record_slot_free_list_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_slot        (s_slot),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_placed_slot (m_placed_slot),
        .m_read_data   (m_read_data),
        .m_live        (m_live)
    );

    rsfl_result_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_slot        (s_slot),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_placed_slot (m_placed_slot),
        .m_read_data   (m_read_data),
        .m_live        (m_live),
        .mismatches    (mismatches),
        .pending       (pending),
        .results_seen  (results_seen),
        .full_seen     (full_seen),
        .freed_seen    (freed_seen),
        .unalloc_seen  (unalloc_seen)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver back-pressure, cycling through its own modes
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b1;
        if (rx_hold > 0) begin
            rdy = 1'b0;
            rx_hold--;
        end else begin
            case ((rx_cycle / 97) % 4)
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = rx_cycle[0];
                3: begin
                    if ($urandom_range(0, 15) == 0) begin
                        rx_hold = $urandom_range(2, 10);
                        rdy     = 1'b0;
                    end
                end
                default: rdy = 1'b1;
            endcase
        end
        rx_cycle++;
        m_ready <= rdy;
    end

    task automatic send_op(input action_t act, input logic [SLOT_W-1:0] idx,
                           input logic [DATA_W-1:0] word);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_action  <= act;
        s_slot    <= idx;
        s_payload <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (act == ACT_ADD) adds_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 5)) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic send_random(input int pct_add, input int pct_del, input int pct_read);
        int                roll;
        int                span;
        action_t           act;
        logic [SLOT_W-1:0] idx;
        logic [DATA_W-1:0] word;
        roll = $urandom_range(0, 99);
        if (roll < pct_add)
            act = ACT_ADD;
        else if (roll < pct_add + pct_del)
            act = ACT_DELETE;
        else if (roll < pct_add + pct_del + pct_read)
            act = ACT_READ;
        else
            act = ACT_NOP;
        // mostly aim at slots up to the number of adds sent so far, sometimes anywhere
        span = (adds_sent > 255) ? 255 : adds_sent;
        if ($urandom_range(0, 9) == 0)
            idx = SLOT_W'($urandom_range(0, 255));
        else
            idx = SLOT_W'($urandom_range(0, span));
        case ($urandom_range(0, 15))
            0:       word = '0;
            1:       word = '1;
            default: word = {$urandom, $urandom};
        endcase
        send_op(act, idx, word);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_action  = ACT_NOP;
        s_slot    = '0;
        s_payload = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty store, no-op, then build and unwind a short free list
        send_op(ACT_READ,   8'd0,   64'h0123_4567_89ab_cdef);
        send_op(ACT_DELETE, 8'd255, '0);
        send_op(ACT_NOP,    8'd255, '1);
        send_op(ACT_ADD,    8'd255, '0);
        send_op(ACT_ADD,    8'd0,   '1);
        send_op(ACT_ADD,    8'd7,   64'ha5a5_5a5a_f00f_0ff0);
        send_op(ACT_READ,   8'd1,   '0);
        send_op(ACT_READ,   8'd2,   '0);
        send_op(ACT_READ,   8'd3,   '0);
        send_op(ACT_DELETE, 8'd1,   '0);
        send_op(ACT_DELETE, 8'd1,   '0);
        send_op(ACT_READ,   8'd1,   '0);
        send_op(ACT_DELETE, 8'd0,   '0);
        send_op(ACT_ADD,    8'd0,   64'h8000_0000_0000_0001);
        send_op(ACT_ADD,    8'd0,   64'h7fff_ffff_ffff_fffe);
        send_op(ACT_ADD,    8'd0,   64'h5555_5555_5555_5555);
        send_op(ACT_DELETE, 8'd2,   '0);
        send_op(ACT_DELETE, 8'd3,   '0);
        send_op(ACT_READ,   8'd3,   '0);
        send_op(ACT_ADD,    8'd0,   64'haaaa_aaaa_aaaa_aaaa);
        send_op(ACT_ADD,    8'd0,   64'hffff_0000_ffff_0000);
        send_op(ACT_READ,   8'd4,   '0);

        // fill past capacity, then churn the free list
        repeat (FILL_BEATS) send_random(88, 5, 5);
        repeat (MIX_BEATS) send_random(30, 35, 25);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);

        $display("%0d beats driven (%0d adds), %0d results checked", beats_sent, adds_sent,
                 results_seen);
        $display("full-store adds %0d, double deletes %0d, never-allocated accesses %0d",
                 full_seen, freed_seen, unalloc_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
